// ===== rtl/plcm_pkg.sv =====
// Package for the piecewise linear colour map.
// Holds field widths, opcodes, channel codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plcm_pkg;

  localparam int SAMPLE_W         = 32;
  localparam int INDEX_W          = 4;
  localparam int COLOUR_W         = 16;
  localparam int COUNT_W          = 5;
  localparam int LAMBDA_W         = 17;
  localparam int FRAC_W           = 16;
  localparam int NUM_CHAN         = 3;
  localparam int MAX_POINTS_DEF   = 16;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int DIV_CNT_W        = 5;

  localparam logic [LAMBDA_W-1:0] ONE_Q16 = LAMBDA_W'(1 << FRAC_W);
  localparam logic [COUNT_W-1:0]  POINTS_RESET = COUNT_W'(2);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PICK = 1'b1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic       load_wr;
    logic       capture;
    logic       rd_en;
    logic       take_lo;
    logic       take_hi;
    logic       prep;
    logic       div_first;
    logic       div_step;
    logic       mul;
    logic       acc;
    logic       clr_res;
    logic       out_load;
    logic [1:0] chan;
  } plcm_cmd_t;

  typedef struct packed {
    logic s_above;
    logic s_below;
    logic out_free;
  } plcm_stat_t;

endpackage

`default_nettype wire

// ===== rtl/plcm_ctrl.sv =====
// Controller of the colour map: state machine, table addressing and step counters.
// Depends on plcm_pkg; drives the datapath plcm_dp through plcm_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module plcm_ctrl
  import plcm_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_opcode,
  input  wire logic               cfg_wr_en,
  input  wire logic [COUNT_W-1:0] cfg_wr_data,
  input  wire plcm_stat_t         stat,
  output plcm_cmd_t               cmd,
  output logic [AW-1:0]           rd_addr
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LAST = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_RLO  = 4'd3;
  localparam logic [3:0] S_RHI  = 4'd4;
  localparam logic [3:0] S_PREP = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;
  localparam logic [3:0] S_ZERO = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]           state_r, state_nxt;
  logic [AW-1:0]        k_r, k_nxt;
  logic [AW-1:0]        hi_r, hi_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]           chan_r, chan_nxt;
  logic [COUNT_W-1:0]   pts_r;
  logic [AW-1:0]        last_idx;
  logic                 accept;

  always_comb begin
    if (int'(pts_r) < 2) begin
      last_idx = AW'(1);
    end else if (int'(pts_r) > MAX_POINTS) begin
      last_idx = AW'(MAX_POINTS - 1);
    end else begin
      last_idx = AW'(int'(pts_r) - 1);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    hi_nxt    = hi_r;
    cnt_nxt   = cnt_r;
    chan_nxt  = chan_r;
    cmd       = '0;
    cmd.chan  = chan_r;
    rd_addr   = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            cmd.rd_en   = 1'b1;
            rd_addr     = last_idx;
            state_nxt   = S_LAST;
          end
        end
      end
      S_LAST: begin
        if (stat.s_above) begin
          state_nxt = S_ZERO;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = '0;
          k_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (k_r == '0 && stat.s_below) begin
          state_nxt = S_ZERO;
        end else if (!stat.s_above || k_r == last_idx) begin
          cmd.rd_en = 1'b1;
          if (k_r == '0) begin
            rd_addr = '0;
            hi_nxt  = AW'(1);
          end else begin
            rd_addr = k_r - AW'(1);
            hi_nxt  = k_r;
          end
          state_nxt = S_RLO;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = k_r + AW'(1);
          k_nxt     = k_r + AW'(1);
        end
      end
      S_RLO: begin
        cmd.take_lo = 1'b1;
        cmd.rd_en   = 1'b1;
        rd_addr     = hi_r;
        state_nxt   = S_RHI;
      end
      S_RHI: begin
        cmd.take_hi = 1'b1;
        state_nxt   = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt_r == '0);
        cnt_nxt       = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(LAMBDA_W - 1)) begin
          chan_nxt  = CH_RED;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (chan_r == CH_BLUE) begin
          state_nxt = S_DONE;
        end else begin
          chan_nxt  = chan_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_ZERO: begin
        cmd.clr_res = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      hi_r    <= '0;
      cnt_r   <= '0;
      chan_r  <= CH_RED;
      pts_r   <= POINTS_RESET;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      hi_r    <= hi_nxt;
      cnt_r   <= cnt_nxt;
      chan_r  <= chan_nxt;
      if (cfg_wr_en) begin
        pts_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/plcm_dp.sv =====
// Datapath of the colour map: entry memory, comparisons, lambda divider,
// channel blend and output register. Depends on plcm_pkg; driven by plcm_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module plcm_dp
  import plcm_pkg::*;
#(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire plcm_cmd_t                  cmd,
  input  wire logic [AW-1:0]              rd_addr,
  output plcm_stat_t                      stat,
  input  wire logic [INDEX_W-1:0]         in_entry_index,
  input  wire logic signed [SAMPLE_W-1:0] in_entry_breakpoint,
  input  wire logic [COLOUR_W-1:0]        in_entry_red,
  input  wire logic [COLOUR_W-1:0]        in_entry_green,
  input  wire logic [COLOUR_W-1:0]        in_entry_blue,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_in_range,
  output logic [COLOUR_W-1:0]             out_red_out,
  output logic [COLOUR_W-1:0]             out_green_out,
  output logic [COLOUR_W-1:0]             out_blue_out
);

  localparam int CB  = CHANNEL_BITS;
  localparam int CW  = NUM_CHAN * CB;
  localparam int BW  = SAMPLE_W + CW;
  localparam int MW  = CB + LAMBDA_W + 2;
  localparam int PW  = MW + 1;
  localparam int SW  = PW - FRAC_W;
  localparam logic [SW-1:0] CHAN_MAX = SW'((1 << CB) - 1);

  logic [BW-1:0]               mem [MAX_POINTS];
  logic [BW-1:0]               rd_q_r;
  logic signed [SAMPLE_W-1:0]  sample_r;
  logic signed [SAMPLE_W-1:0]  bp_lo_r, bp_hi_r;
  logic [CW-1:0]               col_lo_r, col_hi_r;
  logic [SAMPLE_W-1:0]         span_r, num_r;
  logic                        lam_ok_r;
  logic [SAMPLE_W:0]           rem_r;
  logic [LAMBDA_W-1:0]         quo_r;
  logic signed [MW-1:0]        prod_r;
  logic [CB-1:0]               res_r [NUM_CHAN];
  logic                        res_in_range_r;
  logic                        out_valid_r, out_in_range_r;
  logic [COLOUR_W-1:0]         out_red_r, out_green_r, out_blue_r;

  logic signed [SAMPLE_W-1:0]  rd_bp;
  logic signed [SAMPLE_W:0]    span_full, num_full;
  logic [SAMPLE_W:0]           trial, trial_sub;
  logic                        trial_ge;
  logic [LAMBDA_W-1:0]         lambda;
  logic [CB-1:0]               c_lo, c_hi;
  logic signed [CB:0]          c_diff;
  logic signed [LAMBDA_W:0]    lambda_s;
  logic signed [PW-1:0]        blend_sum;
  logic [SW-1:0]               blend_sh;
  logic [CB-1:0]               blend_sat;
  logic [AW-1:0]               wr_addr;
  logic                        wr_ok;

  assign rd_bp   = rd_q_r[BW-1 -: SAMPLE_W];
  assign wr_addr = AW'(in_entry_index);
  assign wr_ok   = int'(in_entry_index) < MAX_POINTS;

  assign stat.s_above  = sample_r > rd_bp;
  assign stat.s_below  = sample_r < rd_bp;
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_wr && wr_ok) begin
      mem[wr_addr] <= {in_entry_breakpoint, in_entry_red[CB-1:0],
                       in_entry_green[CB-1:0], in_entry_blue[CB-1:0]};
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign span_full = {bp_hi_r[SAMPLE_W-1], bp_hi_r} - {bp_lo_r[SAMPLE_W-1], bp_lo_r};
  assign num_full  = {sample_r[SAMPLE_W-1], sample_r} - {bp_lo_r[SAMPLE_W-1], bp_lo_r};

  assign trial     = cmd.div_first ? {1'b0, num_r} : {rem_r[SAMPLE_W-1:0], 1'b0};
  assign trial_ge  = trial >= {1'b0, span_r};
  assign trial_sub = trial - {1'b0, span_r};

  always_comb begin
    if (!lam_ok_r) begin
      lambda = '0;
    end else if (quo_r > ONE_Q16) begin
      lambda = ONE_Q16;
    end else begin
      lambda = quo_r;
    end
  end

  always_comb begin
    case (cmd.chan)
      CH_RED: begin
        c_lo = col_lo_r[3*CB-1 -: CB];
        c_hi = col_hi_r[3*CB-1 -: CB];
      end
      CH_GREEN: begin
        c_lo = col_lo_r[2*CB-1 -: CB];
        c_hi = col_hi_r[2*CB-1 -: CB];
      end
      CH_BLUE: begin
        c_lo = col_lo_r[CB-1:0];
        c_hi = col_hi_r[CB-1:0];
      end
      default: begin
        c_lo = '0;
        c_hi = '0;
      end
    endcase
  end

  assign c_diff    = $signed({1'b0, c_hi}) - $signed({1'b0, c_lo});
  assign lambda_s  = $signed({1'b0, lambda});
  assign blend_sum = {prod_r[MW-1], prod_r}
                   + $signed(PW'({c_lo, {FRAC_W{1'b0}}}))
                   + $signed(PW'(1 << (FRAC_W - 1)));
  assign blend_sh  = blend_sum[PW-1:FRAC_W];

  always_comb begin
    if (blend_sh[SW-1]) begin
      blend_sat = '0;
    end else if (blend_sh > CHAN_MAX) begin
      blend_sat = CHAN_MAX[CB-1:0];
    end else begin
      blend_sat = blend_sh[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample_value;
    end
    if (cmd.take_lo) begin
      bp_lo_r  <= rd_bp;
      col_lo_r <= rd_q_r[CW-1:0];
    end
    if (cmd.take_hi) begin
      bp_hi_r  <= rd_bp;
      col_hi_r <= rd_q_r[CW-1:0];
    end
    if (cmd.prep) begin
      span_r   <= span_full[SAMPLE_W-1:0];
      num_r    <= num_full[SAMPLE_W-1:0];
      lam_ok_r <= (bp_hi_r > bp_lo_r) && (sample_r > bp_lo_r);
    end
    if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_sub : trial;
      quo_r <= {quo_r[LAMBDA_W-2:0], trial_ge};
    end
    if (cmd.mul) begin
      prod_r <= MW'(c_diff * lambda_s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_in_range_r <= 1'b0;
      for (int i = 0; i < NUM_CHAN; i++) begin
        res_r[i] <= '0;
      end
    end else if (cmd.clr_res) begin
      res_in_range_r <= 1'b0;
      for (int i = 0; i < NUM_CHAN; i++) begin
        res_r[i] <= '0;
      end
    end else begin
      if (cmd.prep) begin
        res_in_range_r <= 1'b1;
      end
      if (cmd.acc) begin
        case (cmd.chan)
          CH_RED:   res_r[0] <= blend_sat;
          CH_GREEN: res_r[1] <= blend_sat;
          CH_BLUE:  res_r[2] <= blend_sat;
          default:  res_r[0] <= res_r[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_in_range_r <= res_in_range_r;
      out_red_r      <= COLOUR_W'(res_r[0]);
      out_green_r    <= COLOUR_W'(res_r[1]);
      out_blue_r     <= COLOUR_W'(res_r[2]);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_in_range  = out_in_range_r;
  assign out_red_out   = out_red_r;
  assign out_green_out = out_green_r;
  assign out_blue_out  = out_blue_r;

endmodule

`default_nettype wire

// ===== rtl/piecewise_linear_colour_map.sv =====
// Top level of the piecewise linear colour map.
// Instantiates the controller plcm_ctrl and the datapath plcm_dp; uses plcm_pkg.
//
// An input word with opcode load writes one breakpoint and its colour into the
// entry memory in the cycle it is accepted and gives no result. A word with
// opcode pick gives exactly one result word on the out_ channel.
// Both channels use valid/ready. The cfg_ port writes the count of breakpoints
// in use with no wait; write it only while the block is idle.
// A pick reads the last breakpoint, then scans the memory from entry 0 one
// entry per cycle for the first breakpoint not below the sample, rereads the
// two segment ends, runs a 17-step restoring divider for lambda and blends
// the three channels through one shared multiplier. The next word is accepted
// once the result has been loaded into the output register.
// The result sits in an output register, so the next word is accepted while
// it waits; only a second finished result waits for a stalled receiver.
// Reset clears the control state and sets the count in use to 2; the entry
// memory is not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_colour_map
  import plcm_pkg::*;
#(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_opcode,
  input  wire logic [INDEX_W-1:0]         in_entry_index,
  input  wire logic signed [SAMPLE_W-1:0] in_entry_breakpoint,
  input  wire logic [COLOUR_W-1:0]        in_entry_red,
  input  wire logic [COLOUR_W-1:0]        in_entry_green,
  input  wire logic [COLOUR_W-1:0]        in_entry_blue,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_in_range,
  output logic [COLOUR_W-1:0]             out_red_out,
  output logic [COLOUR_W-1:0]             out_green_out,
  output logic [COLOUR_W-1:0]             out_blue_out,
  input  wire logic                       cfg_wr_en,
  input  wire logic [COUNT_W-1:0]         cfg_wr_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  plcm_cmd_t     cmd;
  plcm_stat_t    stat;
  logic [AW-1:0] rd_addr;

  plcm_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .stat        (stat),
    .cmd         (cmd),
    .rd_addr     (rd_addr)
  );

  plcm_dp #(
    .MAX_POINTS   (MAX_POINTS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .rd_addr             (rd_addr),
    .stat                (stat),
    .in_entry_index      (in_entry_index),
    .in_entry_breakpoint (in_entry_breakpoint),
    .in_entry_red        (in_entry_red),
    .in_entry_green      (in_entry_green),
    .in_entry_blue       (in_entry_blue),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_in_range        (out_in_range),
    .out_red_out         (out_red_out),
    .out_green_out       (out_green_out),
    .out_blue_out        (out_blue_out)
  );

endmodule

`default_nettype wire

// ===== dv/plcm_colour_checker.sv =====
// Checker for the piecewise linear color map: watches the input, result and config ports.
// It keeps its own copy of the breakpoint and color tables and predicts every result word.
// Depends on plcm_pkg for field widths and opcodes.
`timescale 1ns / 1ps

module plcm_colour_checker
  import plcm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [INDEX_W-1:0]         in_entry_index,
  input  logic signed [SAMPLE_W-1:0] in_entry_breakpoint,
  input  logic [COLOUR_W-1:0]        in_entry_red,
  input  logic [COLOUR_W-1:0]        in_entry_green,
  input  logic [COLOUR_W-1:0]        in_entry_blue,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_in_range,
  input  logic [COLOUR_W-1:0]        out_red_out,
  input  logic [COLOUR_W-1:0]        out_green_out,
  input  logic [COLOUR_W-1:0]        out_blue_out,
  input  logic                       cfg_wr_en,
  input  logic [COUNT_W-1:0]         cfg_wr_data,
  output int unsigned                bad_words,
  output int unsigned                words_owed
);

  typedef struct packed {
    logic                in_range;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
  } colour_word_t;

  localparam longint unsigned CHAN_LIMIT = (64'd1 << CHANNEL_BITS_DEF) - 1;

  logic signed [SAMPLE_W-1:0] breakpoints [MAX_POINTS_DEF];
  logic [COLOUR_W-1:0]        entry_colours [MAX_POINTS_DEF][NUM_CHAN];
  logic [COUNT_W-1:0]         points_setting = POINTS_RESET;
  colour_word_t               owed_colours [$];
  int unsigned                mismatches = 0;

  initial begin
    bad_words = 0;
    words_owed = 0;
  end

  function automatic colour_word_t colour_at(input logic signed [SAMPLE_W-1:0] sample);
    colour_word_t        word;
    int                  n;
    int                  hi;
    int                  lo;
    bit                  found;
    longint              s;
    longint              lo_bp;
    longint              hi_bp;
    longint unsigned     num;
    longint unsigned     span;
    longint unsigned     lambda;
    longint unsigned     mix;
    logic [COLOUR_W-1:0] blend [NUM_CHAN];
    word = '0;
    lambda = 0;
    found = 0;
    if (points_setting < 2) n = 2;
    else if (points_setting > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
    else n = points_setting;
    s = sample;
    if (s < longint'(breakpoints[0]) || s > longint'(breakpoints[n-1])) return word;
    hi = n - 1;
    for (int k = 0; k < n; k++) begin
      if (!found && breakpoints[k] >= sample) begin
        hi = k;
        found = 1;
      end
    end
    if (hi == 0) begin
      hi = 1;
      lo = 0;
    end else begin
      lo = hi - 1;
    end
    lo_bp = breakpoints[lo];
    hi_bp = breakpoints[hi];
    if (hi_bp > lo_bp && s > lo_bp) begin
      num = s - lo_bp;
      span = hi_bp - lo_bp;
      lambda = (num << FRAC_W) / span;
      if (lambda > ONE_Q16) lambda = ONE_Q16;
    end
    for (int j = 0; j < NUM_CHAN; j++) begin
      mix = (entry_colours[lo][j] * (ONE_Q16 - lambda) + entry_colours[hi][j] * lambda
             + 64'd32768) >> FRAC_W;
      if (mix > CHAN_LIMIT) mix = CHAN_LIMIT;
      blend[j] = mix[COLOUR_W-1:0];
    end
    word.in_range = 1'b1;
    word.red = blend[CH_RED];
    word.green = blend[CH_GREEN];
    word.blue = blend[CH_BLUE];
    return word;
  endfunction

  always @(posedge clk) begin
    colour_word_t want;
    colour_word_t got;
    got = '{out_in_range, out_red_out, out_green_out, out_blue_out};
    if (!rst_n) begin
      points_setting = POINTS_RESET;
    end else begin
      if (cfg_wr_en) points_setting = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (owed_colours.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word range=%0d rgb=%h/%h/%h", $realtime,
                     got.in_range, got.red, got.green, got.blue);
        end else begin
          want = owed_colours.pop_front();
          if (want.in_range !== got.in_range || want.red !== got.red ||
              want.green !== got.green || want.blue !== got.blue) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: color mismatch: expected range=%0d rgb=%h/%h/%h, ",
                        "got range=%0d rgb=%h/%h/%h"},
                       $realtime, want.in_range, want.red, want.green, want.blue,
                       got.in_range, got.red, got.green, got.blue);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_opcode == OP_LOAD) begin
          breakpoints[in_entry_index] = in_entry_breakpoint;
          entry_colours[in_entry_index][CH_RED] = in_entry_red & CHAN_LIMIT[COLOUR_W-1:0];
          entry_colours[in_entry_index][CH_GREEN] = in_entry_green & CHAN_LIMIT[COLOUR_W-1:0];
          entry_colours[in_entry_index][CH_BLUE] = in_entry_blue & CHAN_LIMIT[COLOUR_W-1:0];
        end else begin
          owed_colours.push_back(colour_at(in_sample_value));
        end
      end
    end
    bad_words <= mismatches;
    words_owed <= owed_colours.size();
  end

endmodule

// ===== dv/tb_piecewise_linear_colour_map.sv =====
// Testbench top for the piecewise linear color map: drives table loads, picks and count writes.
// Results are checked by plcm_colour_checker; this module only makes stimulus and gives the verdict.
// Depends on plcm_pkg, plcm_colour_checker and the piecewise_linear_colour_map RTL.
`timescale 1ns / 1ps

module tb_piecewise_linear_colour_map;
  import plcm_pkg::*;

  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES          = 12;
  localparam int PHASE_WORDS     = 88;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_opcode;
  logic [INDEX_W-1:0]         in_entry_index;
  logic signed [SAMPLE_W-1:0] in_entry_breakpoint;
  logic [COLOUR_W-1:0]        in_entry_red;
  logic [COLOUR_W-1:0]        in_entry_green;
  logic [COLOUR_W-1:0]        in_entry_blue;
  logic signed [SAMPLE_W-1:0] in_sample_value;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_in_range;
  logic [COLOUR_W-1:0]        out_red_out;
  logic [COLOUR_W-1:0]        out_green_out;
  logic [COLOUR_W-1:0]        out_blue_out;
  logic                       cfg_wr_en;
  logic [COUNT_W-1:0]         cfg_wr_data;
  int unsigned                bad_words;
  int unsigned                words_owed;

  bit                         calm = 0;
  bit                         hold_request = 0;
  int                         points_now = POINTS_RESET;
  logic signed [SAMPLE_W-1:0] loaded_bp [MAX_POINTS_DEF];

  int phase_points [PHASES] = '{16, 0, 3, 31, 1, 17, 8, 2, 16, 5, 12, 16};
  int phase_style [PHASES]  = '{1, 0, 1, 2, 1, 3, 1, 0, 2, 1, 3, 1};

  piecewise_linear_colour_map dut (.*);

  plcm_colour_checker colour_watch (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_piecewise_linear_colour_map: errors");
    $finish;
  end

  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_request = 0;
      end else begin
        out_ready = calm || ($urandom_range(99) >= 28);
      end
    end
  end

  function automatic int active_points();
    if (points_now < 2) return 2;
    if (points_now > MAX_POINTS_DEF) return MAX_POINTS_DEF;
    return points_now;
  endfunction

  function automatic logic [COLOUR_W-1:0] any_colour();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return COLOUR_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sample_for_table();
    int                  n;
    longint              lo;
    longint              hi;
    longint unsigned     width;
    longint unsigned     offset;
    n = active_points();
    lo = loaded_bp[0];
    hi = loaded_bp[n-1];
    case ($urandom_range(9))
      0: return $urandom;
      1: return loaded_bp[$urandom_range(n - 1)];
      2: return loaded_bp[$urandom_range(n - 1)] + $signed($urandom_range(2)) - 1;
      3: return $urandom_range(1) ? loaded_bp[0] - 1 : loaded_bp[n-1] + 1;
      default: begin
        if (hi < lo) return $urandom;
        width = hi - lo;
        offset = {$urandom, $urandom} % (width + 1);
        return SAMPLE_W'(lo + longint'(offset));
      end
    endcase
  endfunction

  task automatic push_word(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic signed [SAMPLE_W-1:0] bp,
                           input logic [COLOUR_W-1:0] red, green, blue,
                           input logic signed [SAMPLE_W-1:0] sample);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_opcode = op;
    in_entry_index = idx;
    in_entry_breakpoint = bp;
    in_entry_red = red;
    in_entry_green = green;
    in_entry_blue = blue;
    in_sample_value = sample;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic load_entry(input int idx, input logic signed [SAMPLE_W-1:0] bp,
                            input logic [COLOUR_W-1:0] red, green, blue);
    loaded_bp[idx] = bp;
    push_word(OP_LOAD, INDEX_W'(idx), bp, red, green, blue, $urandom);
  endtask

  task automatic pick(input logic signed [SAMPLE_W-1:0] sample);
    push_word(OP_PICK, INDEX_W'($urandom), $urandom, COLOUR_W'($urandom),
              COLOUR_W'($urandom), COLOUR_W'($urandom), sample);
  endtask

  task automatic quiesce();
    in_valid = 0;
    while (words_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_points(input int value);
    quiesce();
    cfg_wr_en = 1;
    cfg_wr_data = COUNT_W'(value);
    points_now = value;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  task automatic fill_table(input int style);
    logic signed [SAMPLE_W-1:0] vals [MAX_POINTS_DEF];
    logic signed [SAMPLE_W-1:0] key;
    int                         n;
    int                         j;
    int                         pos;
    n = active_points();
    vals[0] = $signed($urandom) >>> 2;
    for (int k = 0; k < MAX_POINTS_DEF; k++) begin
      case (style)
        0, 2: vals[k] = $urandom;
        1: if (k > 0)
          vals[k] = vals[k-1] + ($urandom_range(7) == 0 ? 0 : $urandom_range(1, 32'h30000));
        default: vals[k] = ($signed($urandom_range(4)) - 2) * 32'sh10000;
      endcase
    end
    if (style == 0) begin
      for (int i = 1; i < MAX_POINTS_DEF; i++) begin
        key = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > key) begin
          vals[j+1] = vals[j];
          j--;
        end
        vals[j+1] = key;
      end
    end else if (style == 2) begin
      // Unsorted interior, but the first and last entries in use bracket the rest.
      pos = 0;
      for (int k = 1; k < n; k++) if (vals[k] < vals[pos]) pos = k;
      key = vals[0];
      vals[0] = vals[pos];
      vals[pos] = key;
      pos = n - 1;
      for (int k = 1; k < n; k++) if (vals[k] > vals[pos]) pos = k;
      key = vals[n-1];
      vals[n-1] = vals[pos];
      vals[pos] = key;
    end
    for (int k = 0; k < MAX_POINTS_DEF; k++)
      load_entry(k, vals[k], any_colour(), any_colour(), any_colour());
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_opcode = OP_LOAD;
    in_entry_index = '0;
    in_entry_breakpoint = '0;
    in_entry_red = '0;
    in_entry_green = '0;
    in_entry_blue = '0;
    in_sample_value = '0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1;

    load_entry(0, 32'sh8000_0000, 16'h0000, 16'hFFFF, 16'h8000);
    load_entry(1, 32'sh7FFF_FFFF, 16'hFFFF, 16'h0000, 16'h0001);
    pick(32'sh8000_0000);
    pick(32'sh7FFF_FFFF);
    pick(32'sh0000_0000);
    pick(32'shFFFF_FFFF);
    load_entry(0, -32'sh10000, 16'h1000, 16'h2000, 16'h3000);
    load_entry(1, 32'sh10000, 16'hFFFF, 16'hFFFF, 16'h0000);
    pick(-32'sh10001);
    pick(32'sh10001);
    pick(32'sh0);
    pick(32'sh10000);
    pick(-32'sh10000);
    load_entry(1, -32'sh10000, 16'h5555, 16'hAAAA, 16'hFFFF);
    pick(-32'sh10000);

    for (int p = 0; p < PHASES; p++) begin
      write_points(phase_points[p]);
      fill_table(phase_style[p]);
      if (p == 3) hold_request = 1;
      if (p == 6) calm = 1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(9) == 0)
          load_entry($urandom_range(MAX_POINTS_DEF - 1), sample_for_table(), any_colour(),
                     any_colour(), any_colour());
        else
          pick(sample_for_table());
      end
      calm = 0;
    end

    in_valid = 0;
    while (words_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_words == 0 && words_owed == 0) begin
      $display("tb_piecewise_linear_colour_map: clean");
    end else begin
      $display("tb_piecewise_linear_colour_map: errors");
    end
    $finish;
  end

endmodule
